/* rtl/core/assert_macros.svh */
// Assertion macros used by the datapath of the sign-class sort core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* rtl/core/scss_pkg.sv */
// Package: sizes, word types and controller/datapath links of the sign-class sort core.
`timescale 1ns / 1ps
package scss_pkg;

    localparam int CAPACITY    = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int IDX_W       = $clog2(CAPACITY);

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] sample_value;
        logic                          final_item;
    } t_in_word;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] sorted_value;
        logic                          end_of_run;
        logic                          set_empty;
        logic [CNT_W-1:0]              positive_total;
        logic [CNT_W-1:0]              negative_total;
        logic [CNT_W-1:0]              zero_total;
        logic                          load_overflow;
    } t_out_word;

    typedef struct packed {
        logic load;       // store one input word
        logic filt_init;  // rewind the filter scan
        logic filt;       // filter scan step
        logic pass_init;  // rewind the sort scan to the pass start
        logic sort;       // minimum search step
        logic swap;       // move the pass head into the minimum's slot
        logic emit;       // load the output register
        logic empty;      // the emitted word reports an empty set
        logic clear;      // drop the run's fill level, counts and flag
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic kept_none;
        logic last_pass;
        logic out_free;
    } t_status;

endpackage

/* rtl/core/scss_ctrl.sv */
// Controller: sequences load, filter, selection-sort passes and output.
`timescale 1ns / 1ps
module scss_ctrl
    import scss_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_final_item,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_in_stall
);

    typedef enum logic [3:0] {
        S_LOAD,
        S_FILT_INIT,
        S_FILT,
        S_PASS_INIT,
        S_SCAN,
        S_SWAP,
        S_EMIT,
        S_EMPTY,
        S_CLEAR
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_LOAD: begin
                o_cmd.load = i_in_valid;
                if (i_in_valid && i_final_item) begin
                    n_state = S_FILT_INIT;
                end
            end
            S_FILT_INIT: begin
                o_cmd.filt_init = 1'b1;
                n_state         = S_FILT;
            end
            S_FILT: begin
                o_cmd.filt = 1'b1;
                if (i_status.scan_done) begin
                    n_state = i_status.kept_none ? S_EMPTY : S_PASS_INIT;
                end
            end
            S_PASS_INIT: begin
                o_cmd.pass_init = 1'b1;
                n_state         = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.sort = 1'b1;
                if (i_status.scan_done) begin
                    n_state = S_SWAP;
                end
            end
            S_SWAP: begin
                o_cmd.swap = 1'b1;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_status.last_pass ? S_CLEAR : S_PASS_INIT;
                end
            end
            S_EMPTY: begin
                if (i_status.out_free) begin
                    o_cmd.emit  = 1'b1;
                    o_cmd.empty = 1'b1;
                    n_state     = S_CLEAR;
                end
            end
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                n_state     = S_LOAD;
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_LOAD);

endmodule

/* rtl/core/scss_dp.sv */
// Datapath: value store, sign counters, scan pipeline, minimum tracker, output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module scss_dp
    import scss_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  t_in_word  i_in_word,
    input  logic      i_out_stall,
    output t_status   o_status,
    output logic      o_out_valid,
    output t_out_word o_out_word
);

    logic signed [VALUE_WIDTH-1:0] mem [CAPACITY];

    logic [CNT_W-1:0] r_fill, r_pos, r_neg, r_zero;
    logic             r_ovf;
    logic [CNT_W-1:0] r_ra, r_k, r_i;
    logic             r_rv, r_first;
    logic signed [VALUE_WIDTH-1:0] r_rd_data, r_min, r_vi;
    logic [IDX_W-1:0] r_rd_idx, r_m;
    logic             r_out_valid;
    t_out_word        r_out;

    logic [CNT_W-1:0] min_cnt, lim, cls_cnt;
    logic             scanning, rd_go, keep, last;
    logic             in_zero, in_neg;

    assign in_zero = (i_in_word.sample_value == '0);
    assign in_neg  = i_in_word.sample_value[VALUE_WIDTH-1];

    always_comb begin
        min_cnt = r_zero;
        if (r_neg < min_cnt) begin
            min_cnt = r_neg;
        end
        if (r_pos < min_cnt) begin
            min_cnt = r_pos;
        end
    end

    always_comb begin
        if (r_rd_data == '0) begin
            cls_cnt = r_zero;
        end else if (r_rd_data[VALUE_WIDTH-1]) begin
            cls_cnt = r_neg;
        end else begin
            cls_cnt = r_pos;
        end
    end

    assign keep     = (cls_cnt != min_cnt);
    assign lim      = i_cmd.sort ? r_k : r_fill;
    assign scanning = i_cmd.filt | i_cmd.sort;
    assign rd_go    = scanning && (r_ra < lim);
    assign last     = ((r_i + CNT_W'(1)) == r_k);

    assign o_status.scan_done = (r_ra == lim) && !r_rv;
    assign o_status.kept_none = (r_k == '0);
    assign o_status.last_pass = last;
    assign o_status.out_free  = !r_out_valid || !i_out_stall;

    // Store writes: load, compaction during the filter, and the pass swap.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (r_fill < CNT_W'(CAPACITY))) begin
            mem[r_fill[IDX_W-1:0]] <= i_in_word.sample_value;
        end else if (i_cmd.filt && r_rv && keep) begin
            mem[r_k[IDX_W-1:0]] <= r_rd_data;
        end else if (i_cmd.swap) begin
            mem[r_m] <= r_vi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_go) begin
            r_rd_data <= mem[r_ra[IDX_W-1:0]];
            r_rd_idx  <= r_ra[IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_pos       <= '0;
            r_neg       <= '0;
            r_zero      <= '0;
            r_ovf       <= 1'b0;
            r_ra        <= '0;
            r_k         <= '0;
            r_i         <= '0;
            r_rv        <= 1'b0;
            r_first     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                if (r_fill < CNT_W'(CAPACITY)) begin
                    r_fill <= r_fill + CNT_W'(1);
                    if (in_zero) begin
                        r_zero <= r_zero + CNT_W'(1);
                    end else if (in_neg) begin
                        r_neg <= r_neg + CNT_W'(1);
                    end else begin
                        r_pos <= r_pos + CNT_W'(1);
                    end
                end else begin
                    r_ovf <= 1'b1;
                end
            end

            if (i_cmd.filt_init) begin
                r_ra <= '0;
                r_k  <= '0;
                r_i  <= '0;
                r_rv <= 1'b0;
            end else if (i_cmd.pass_init) begin
                r_ra    <= r_i;
                r_rv    <= 1'b0;
                r_first <= 1'b1;
            end else if (scanning) begin
                r_rv <= rd_go;
                if (rd_go) begin
                    r_ra <= r_ra + CNT_W'(1);
                end
            end

            if (i_cmd.filt && r_rv && keep) begin
                r_k <= r_k + CNT_W'(1);
            end

            if (i_cmd.sort && r_rv && r_first) begin
                r_first <= 1'b0;
            end

            if (i_cmd.emit && !i_cmd.empty) begin
                r_i <= r_i + CNT_W'(1);
            end

            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (i_cmd.clear) begin
                r_fill <= '0;
                r_pos  <= '0;
                r_neg  <= '0;
                r_zero <= '0;
                r_ovf  <= 1'b0;
                r_k    <= '0;
                r_i    <= '0;
            end
        end
    end

    // Minimum tracker; the first word of a pass is the pass head.
    always_ff @(posedge i_clk) begin
        if (i_cmd.sort && r_rv) begin
            if (r_first) begin
                r_vi  <= r_rd_data;
                r_min <= r_rd_data;
                r_m   <= r_rd_idx;
            end else if (r_rd_data < r_min) begin
                r_min <= r_rd_data;
                r_m   <= r_rd_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.sorted_value   <= i_cmd.empty ? '0 : r_min;
            r_out.end_of_run     <= i_cmd.empty | last;
            r_out.set_empty      <= i_cmd.empty;
            r_out.positive_total <= r_pos;
            r_out.negative_total <= r_neg;
            r_out.zero_total     <= r_zero;
            r_out.load_overflow  <= r_ovf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    `ASSERT_ALWAYS(a_kept_le_fill, r_k <= r_fill, "kept count exceeds fill level")
    `ASSERT_IMPLIES(a_ovf_full, r_ovf, r_fill == CNT_W'(CAPACITY), "overflow without full store")
    `ASSERT_IMPLIES(a_emit_free, i_cmd.emit, !r_out_valid || !i_out_stall, "emit over a held word")
    `ASSERT_IMPLIES(a_swap_range, i_cmd.swap,
        (CNT_W'(r_m) >= r_i) && (CNT_W'(r_m) < r_k), "swap slot outside unsorted region")

endmodule

/* rtl/core/sign_class_filter_selection_sort_top.sv */
// Top level of the sign-class filter and selection sort core.
// Input channel (i_in_valid, i_in_word, o_in_stall): one signed Q16.16 word per
// accepted cycle; final_item closes the set. Words past CAPACITY are dropped
// and reported through load_overflow; a dropped word with final_item still
// starts the run.
// After the final word the core counts classes (done during load), drops
// every word of the least populated sign class(es), then runs selection sort
// over the kept words through the single read port of the value store.
// The filter scans the filled store once. Each sort pass scans the unsorted
// words, moves the pass head into the minimum's slot, emits the minimum and
// waits out any output stall; the scan reads the store one word per cycle.
// Output channel (o_out_valid, o_out_word, i_out_stall): ascending words,
// end_of_run on the last; with nothing kept, one word with set_empty.
// The output register holds its word while i_out_stall is high; the core
// waits for it before the next pass result and loads nothing during a run.
// Reset (i_rst_n low, synchronous) empties the store, counts and flags.
`timescale 1ns / 1ps
module sign_class_filter_selection_sort_top
    import scss_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_word  i_in_word,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_word o_out_word,
    input  logic      i_out_stall
);

    // Command and status between the sequencer and the datapath.
    t_cmd    cmd;
    t_status status;

    scss_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_final_item (i_in_word.final_item),
        .i_status     (status),
        .o_cmd        (cmd),
        .o_in_stall   (o_in_stall)
    );

    // Store, counters, scan pipeline and output register.
    scss_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_word   (i_in_word),
        .i_out_stall (i_out_stall),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule

/* tb/sv/tb_sign_class_filter_selection_sort_top.sv */
// Testbench for the sign-class filter and selection sort core, self-checking against a predictor.
`timescale 1ns / 1ps
module tb_sign_class_filter_selection_sort_top;
    import scss_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_TICKS = 300;
    localparam int RANDOM_ITEMS = 150;
    localparam int LONG_HOLD    = 400;

    typedef enum int {CLS_ZERO, CLS_NEG, CLS_POS} t_sign_cls;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    t_in_word  i_in_word;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_word o_out_word;
    logic      i_out_stall;

    sign_class_filter_selection_sort_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_word   (i_in_word),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_stall (i_out_stall)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Shadow copy of the core state, updated on every accepted input word.
    logic signed [VALUE_WIDTH-1:0] shadow_store [CAPACITY];
    int                            shadow_fill;
    logic [CNT_W-1:0]              shadow_pos;
    logic [CNT_W-1:0]              shadow_neg;
    logic [CNT_W-1:0]              shadow_zero;
    logic                          shadow_drop;

    // Sorted words still owed by the core, oldest first.
    t_out_word expected_sorted [$];

    int  err_count   = 0;
    int  cycle_count = 0;
    bit  tx_idle_on  = 1'b1;
    bit  rx_idle_on  = 1'b1;
    int  rx_gap      = 0;
    int  hold_left   = 0;

    task automatic flag_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    // Store and count one word; on the final word, filter, sort and queue the run.
    task automatic predict_sorted_run(input logic signed [VALUE_WIDTH-1:0] v, input logic fin);
        logic signed [VALUE_WIDTH-1:0] kept [$];
        logic signed [VALUE_WIDTH-1:0] tmp;
        logic signed [VALUE_WIDTH-1:0] x;
        logic [CNT_W-1:0]              least;
        logic [CNT_W-1:0]              cnt;
        int                            m;
        t_out_word                     w;
        if (shadow_fill < CAPACITY) begin
            shadow_store[shadow_fill[IDX_W-1:0]] = v;
            shadow_fill++;
            if (v == 0) shadow_zero++;
            else if (v < 0) shadow_neg++;
            else shadow_pos++;
        end else begin
            shadow_drop = 1'b1;
        end
        if (!fin) return;

        least = shadow_zero;
        if (shadow_neg < least) least = shadow_neg;
        if (shadow_pos < least) least = shadow_pos;

        // Drop every word whose class holds the least count; an empty class drops nothing.
        for (int i = 0; i < shadow_fill; i++) begin
            x   = shadow_store[i[IDX_W-1:0]];
            cnt = (x == 0) ? shadow_zero : ((x < 0) ? shadow_neg : shadow_pos);
            if (cnt != least) kept = {kept, x};
        end

        for (int i = 0; i + 1 < kept.size(); i++) begin
            m = i;
            for (int j = i + 1; j < kept.size(); j++)
                if (kept[j] < kept[m]) m = j;
            tmp     = kept[i];
            kept[i] = kept[m];
            kept[m] = tmp;
        end

        w                = '0;
        w.positive_total = shadow_pos;
        w.negative_total = shadow_neg;
        w.zero_total     = shadow_zero;
        w.load_overflow  = shadow_drop;
        if (kept.size() == 0) begin
            w.set_empty  = 1'b1;
            w.end_of_run = 1'b1;
            expected_sorted = {expected_sorted, w};
        end else begin
            for (int i = 0; i < kept.size(); i++) begin
                w.sorted_value = kept[i];
                w.end_of_run   = (i == kept.size() - 1);
                expected_sorted = {expected_sorted, w};
            end
        end

        shadow_fill = 0;
        shadow_pos  = '0;
        shadow_neg  = '0;
        shadow_zero = '0;
        shadow_drop = 1'b0;
    endtask

    // Offer one word from the falling edge and hold it until the rising edge that takes it.
    task automatic send_sample(input logic signed [VALUE_WIDTH-1:0] v, input logic fin);
        int gap;
        gap = tx_idle_on ? $urandom_range(19, 0) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid             <= 1'b1;
        i_in_word.sample_value <= v;
        i_in_word.final_item   <= fin;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        predict_sorted_run(v, fin);
    endtask

    // Drop valid, wait for every owed word, then let the core settle.
    task automatic wait_for_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_sorted.size() != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    function automatic logic signed [VALUE_WIDTH-1:0] draw_value(input t_sign_cls cls);
        logic signed [VALUE_WIDTH-1:0] v;
        v = $urandom;
        case (cls)
            CLS_ZERO: v = '0;
            CLS_POS: begin
                case ($urandom_range(0, 5))
                    0: v = 1;
                    1: v = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
                    2, 3: v = $urandom_range(1, 4) << 16;   // repeats on purpose
                    default: v[VALUE_WIDTH-1] = 1'b0;
                endcase
                if (v == 0) v = 1;
            end
            default: begin
                case ($urandom_range(0, 5))
                    0: v = -1;
                    1: v = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
                    2, 3: begin
                        v = $urandom_range(1, 4) << 16;
                        v = -v;
                    end
                    default: v[VALUE_WIDTH-1] = 1'b1;
                endcase
            end
        endcase
        return v;
    endfunction

    // Send one set of the given size with class weights drawn for the whole set.
    task automatic send_random_set(input int size);
        int        wp;
        int        wn;
        int        wz;
        int        r;
        t_sign_cls cls;
        wp = $urandom_range(0, 3);
        wn = $urandom_range(0, 3);
        wz = $urandom_range(0, 3);
        if (wp + wn + wz == 0) wp = 1;
        for (int k = 0; k < size; k++) begin
            r = $urandom_range(0, wp + wn + wz - 1);
            if (r < wp) cls = CLS_POS;
            else if (r < wp + wn) cls = CLS_NEG;
            else cls = CLS_ZERO;
            send_sample(draw_value(cls), k == size - 1);
        end
    endtask

    // One word per class alone in its set.
    task automatic test_single_class_sets();
        send_sample(32'sh7FFF_FFFF, 1'b1);
        send_sample(32'sh8000_0000, 1'b1);
        send_sample(32'sh0000_0000, 1'b1);
        wait_for_results();
    endtask

    // Three-way tie empties the set; zero-count ties keep everything; a lone minimum drops.
    task automatic test_tied_classes();
        send_sample(32'sh0005_0000, 1'b0);
        send_sample(-32'sh0005_0000, 1'b0);
        send_sample(32'sh0000_0000, 1'b1);

        send_sample(32'sh0001_0000, 1'b0);
        send_sample(-32'sh0001_0000, 1'b0);
        send_sample(32'sh0002_0000, 1'b0);
        send_sample(-32'sh0002_0000, 1'b1);

        send_sample(32'sh0003_0000, 1'b0);
        send_sample(32'sh0003_0000, 1'b0);
        send_sample(-32'sh0007_0000, 1'b0);
        send_sample(32'sh0000_0000, 1'b0);
        send_sample(32'sh0000_0000, 1'b0);
        send_sample(32'sh0000_0000, 1'b1);
        wait_for_results();
    endtask

    task automatic test_extreme_values();
        send_sample(32'sh8000_0000, 1'b0);
        send_sample(32'sh7FFF_FFFF, 1'b0);
        send_sample(-32'sd1, 1'b0);
        send_sample(32'sd1, 1'b0);
        send_sample(32'sh0000_0000, 1'b0);
        send_sample(32'sh8000_0001, 1'b0);
        send_sample(32'sh7FFF_FFFE, 1'b1);
        wait_for_results();
    endtask

    // Hold the output long enough that the second set backs up on the input.
    task automatic test_back_pressure();
        @(posedge i_clk);
        hold_left = LONG_HOLD;
        tx_idle_on = 1'b0;
        send_random_set(6);
        send_random_set(5);
        tx_idle_on = 1'b1;
        wait_for_results();
    endtask

    // Mostly short sets, one that runs past capacity; idling switched by phase.
    task automatic test_random_sets();
        int sent;
        int sets;
        int size;
        int big_at;
        sent   = 0;
        sets   = 0;
        big_at = $urandom_range(1, 6);
        while (sent < RANDOM_ITEMS) begin
            if (sent < RANDOM_ITEMS / 3) begin
                tx_idle_on = 1'b1;
                rx_idle_on = 1'b1;
            end else if (sent < 2 * RANDOM_ITEMS / 3) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end else begin
                tx_idle_on = 1'($urandom_range(0, 1));
                rx_idle_on = 1'($urandom_range(0, 1));
            end
            size = (sets == big_at) ? $urandom_range(CAPACITY + 1, CAPACITY + 3)
                                    : $urandom_range(1, 10);
            send_random_set(size);
            sent += size;
            sets++;
            // Pause the sender now and then until the core has drained.
            if ($urandom_range(0, 5) == 0) wait_for_results();
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // Receiver: a long hold first, then the per-word gap drawn at acceptance.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (rx_gap > 0) begin
                rx_gap--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic compare_field(input string name, input logic [63:0] got,
                                 input logic [63:0] want);
        if (got !== want)
            flag_error($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    // Check every accepted output word against the oldest owed word.
    always @(posedge i_clk) begin : check_words
        t_out_word want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (expected_sorted.size() == 0) begin
                flag_error($sformatf("unexpected output word %0h", o_out_word));
            end else begin
                want = expected_sorted.pop_front();
                compare_field("sorted_value", 64'(o_out_word.sorted_value),
                              64'(want.sorted_value));
                compare_field("end_of_run", 64'(o_out_word.end_of_run),
                              64'(want.end_of_run));
                compare_field("set_empty", 64'(o_out_word.set_empty),
                              64'(want.set_empty));
                compare_field("positive_total", 64'(o_out_word.positive_total),
                              64'(want.positive_total));
                compare_field("negative_total", 64'(o_out_word.negative_total),
                              64'(want.negative_total));
                compare_field("zero_total", 64'(o_out_word.zero_total),
                              64'(want.zero_total));
                compare_field("load_overflow", 64'(o_out_word.load_overflow),
                              64'(want.load_overflow));
            end
            if (rx_idle_on) rx_gap = $urandom_range(19, 0);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_sign_class_filter_selection_sort_top: FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_word   = '0;
        shadow_fill = 0;
        shadow_pos  = '0;
        shadow_neg  = '0;
        shadow_zero = '0;
        shadow_drop = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_single_class_sets();
        test_tied_classes();
        test_extreme_values();
        test_back_pressure();
        test_random_sets();
        wait_for_results();

        if (expected_sorted.size() != 0)
            flag_error($sformatf("%0d words never arrived", expected_sorted.size()));
        if (err_count == 0) begin
            $display("tb_sign_class_filter_selection_sort_top: PASS");
        end else begin
            $display("tb_sign_class_filter_selection_sort_top: FAIL");
        end
        $finish;
    end

endmodule
